/* rtl/core/scs_pkg.sv */
package scs_pkg;

    // pipeline depths, in register stages
    localparam int SIN_ITERS = 6;
    localparam int SIN_LAT   = 5 + 3 * SIN_ITERS;
    localparam int FRAME_LAT = 6;
    localparam int TONE_LAT  = 3;
    localparam int PIPE_LAT  = SIN_LAT + FRAME_LAT;

    // binary angles and Q30 constants
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

    // series divisors k*(k+1) for k = 12, 10, ..., 2 and their reciprocals in 2^-32
    localparam logic [7:0] ITER_DIV [0:SIN_ITERS-1] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [29:0] ITER_RECIP [0:SIN_ITERS-1] = '{
        30'((64'd1 << 32) / 64'd156), 30'((64'd1 << 32) / 64'd110),
        30'((64'd1 << 32) / 64'd72),  30'((64'd1 << 32) / 64'd42),
        30'((64'd1 << 32) / 64'd20),  30'((64'd1 << 32) / 64'd6)};

    // horizon margin: floor(0.03 * 2^30)
    localparam logic signed [33:0] ALT_FLOOR = 34'sd32212254;
    localparam logic [15:0] SKY_SCALE = 16'd40000;
    localparam logic [18:0] POS_MAX   = 19'd40000;

    // brightness divider 25500 reduced by 6
    localparam logic [12:0] BR_DIV   = 13'd4250;
    localparam logic [19:0] BR_RECIP = 20'((64'd1 << 32) / 64'd4250);
    localparam logic [14:0] BR_LOW   = 15'd1966;
    localparam logic [14:0] BR_HIGH  = 15'd24576;

    // tint dividers 100*204 and 100*306
    localparam logic [14:0] TINT_DIV_LO   = 15'd20400;
    localparam logic [14:0] TINT_DIV_HI   = 15'd30600;
    localparam logic [17:0] TINT_RECIP_LO = 18'((64'd1 << 32) / 64'd20400);
    localparam logic [17:0] TINT_RECIP_HI = 18'((64'd1 << 32) / 64'd30600);

    // tint break points in hundredths: blue-white, white, yellow, orange, red
    localparam logic [6:0] TINT_PT [0:4][0:2] = '{
        '{7'd61,  7'd70,  7'd100},
        '{7'd100, 7'd100, 7'd100},
        '{7'd100, 7'd96,  7'd84},
        '{7'd100, 7'd80,  7'd55},
        '{7'd100, 7'd62,  7'd42}};

    // configuration register indexes
    localparam logic [1:0] REG_SIDEREAL  = 2'd0;
    localparam logic [1:0] REG_LATITUDE  = 2'd1;
    localparam logic [1:0] REG_LONGITUDE = 2'd2;

    typedef logic signed [33:0] qv_t;

    typedef struct packed {
        logic signed [31:0] sd;
        logic signed [31:0] cd;
        logic signed [31:0] sh;
        logic signed [31:0] ch;
        logic signed [31:0] sl;
        logic signed [31:0] cl;
        logic signed [31:0] so;
        logic signed [31:0] co;
    } trig_t;

    // Q30 product, magnitude rounded half away from zero
    function automatic qv_t mulq(qv_t a, qv_t b);
        logic [32:0] ma;
        logic [32:0] mb;
        logic [65:0] p;
        qv_t         m;
        ma = a[33] ? 33'(-a) : 33'(a);
        mb = b[33] ? 33'(-b) : 33'(b);
        p  = {33'b0, ma} * {33'b0, mb} + (66'd1 << 29);
        m  = qv_t'(p[63:30]);
        return (a[33] != b[33]) ? -m : m;
    endfunction

endpackage

/* rtl/core/scs_sin.sv */
module scs_sin
    import scs_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [31:0] value
);

    logic [30:0] r_reg;
    logic [62:0] xp_reg;
    logic [30:0] x_reg;
    logic [61:0] x2p_reg;
    logic        sg_reg [0:SIN_LAT-2];

    logic [62:0] pa_reg  [0:SIN_ITERS-1];
    logic [30:0] xa_reg  [0:SIN_ITERS-1];
    logic [31:0] x2a_reg [0:SIN_ITERS-1];
    logic [61:0] mb_reg  [0:SIN_ITERS-1];
    logic [31:0] vb_reg  [0:SIN_ITERS-1];
    logic [30:0] xb_reg  [0:SIN_ITERS-1];
    logic [31:0] x2b_reg [0:SIN_ITERS-1];
    logic [30:0] tc_reg  [0:SIN_ITERS-1];
    logic [30:0] xc_reg  [0:SIN_ITERS-1];
    logic [31:0] x2c_reg [0:SIN_ITERS-1];

    logic [30:0] t_in  [0:SIN_ITERS-1];
    logic [30:0] x_in  [0:SIN_ITERS-1];
    logic [31:0] x2_in [0:SIN_ITERS-1];

    logic [61:0] sp_reg;
    logic [31:0] s_cl;
    logic signed [31:0] value_reg;

    // quadrant fold, then scale by pi/2, then square
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= angle[30] ? (Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
            xp_reg  <= {32'b0, r_reg} * {31'b0, PI_Q30};
            x_reg   <= xp_reg[61:31];
            x2p_reg <= {31'b0, xp_reg[61:31]} * {31'b0, xp_reg[61:31]};
        end
    end

    // sign of the lower half turn follows the item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg_reg[0] <= angle[31];
            for (int k = 1; k < SIN_LAT - 1; k++)
            begin
                sg_reg[k] <= sg_reg[k-1];
            end
        end
    end

    // series terms: multiply, reciprocal multiply, correct and subtract
    for (genvar i = 0; i < SIN_ITERS; i++)
    begin : g_term
        logic [29:0] q0;
        logic [37:0] qd;
        logic [37:0] rem;
        logic [30:0] q;

        if (i == 0)
        begin : g_first
            assign t_in[i]  = Q30_ONE;
            assign x_in[i]  = x_reg;
            assign x2_in[i] = x2p_reg[61:30];
        end
        else
        begin : g_next
            assign t_in[i]  = tc_reg[i-1];
            assign x_in[i]  = xc_reg[i-1];
            assign x2_in[i] = x2c_reg[i-1];
        end

        always_comb
        begin
            q0  = mb_reg[i][61:32];
            qd  = {8'b0, q0} * {30'b0, ITER_DIV[i]};
            rem = {6'b0, vb_reg[i]} - qd;
            q   = {1'b0, q0} + 31'(rem >= {30'b0, ITER_DIV[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[i]  <= {31'b0, x2_in[i]} * {32'b0, t_in[i]};
                xa_reg[i]  <= x_in[i];
                x2a_reg[i] <= x2_in[i];
                mb_reg[i]  <= {30'b0, pa_reg[i][61:30]} * {32'b0, ITER_RECIP[i]};
                vb_reg[i]  <= pa_reg[i][61:30];
                xb_reg[i]  <= xa_reg[i];
                x2b_reg[i] <= x2a_reg[i];
                tc_reg[i]  <= Q30_ONE - q;
                xc_reg[i]  <= xb_reg[i];
                x2c_reg[i] <= x2b_reg[i];
            end
        end
    end

    // final product, limit to one, apply sign
    always_comb
    begin
        s_cl = (sp_reg[61:30] > {1'b0, Q30_ONE}) ? {1'b0, Q30_ONE} : sp_reg[61:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg    <= {31'b0, xc_reg[SIN_ITERS-1]} * {31'b0, tc_reg[SIN_ITERS-1]};
            value_reg <= sg_reg[SIN_LAT-2] ? -$signed(s_cl) : $signed(s_cl);
        end
    end

    assign value = value_reg;

endmodule

/* rtl/core/scs_frame.sv */
module scs_frame
    import scs_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  trig_t              trig,
    output logic               visible,
    output logic signed [16:0] pos [0:2]
);

    qv_t sd, cd, sh, ch, sl, cl, so, co;

    qv_t cdcl1, cdsl1, slsd1, east1, sdcl1, slco1, clco1, slso1, clso1;
    qv_t ch1, so1, co1, cl1, sl1;
    qv_t up2, north2, east2, slco2, clco2, slso2, clso2, so2, co2, cl2, sl2;
    qv_t tx_reg [0:2];
    qv_t ty_reg [0:2];
    qv_t tz_reg [0:1];
    logic        vis3_reg, vis4_reg, vis5_reg, vis6_reg;
    qv_t         ec [0:2];
    logic [32:0] mag4_reg [0:2];
    logic        neg4_reg [0:2];
    logic [48:0] mp5_reg  [0:2];
    logic        neg5_reg [0:2];
    logic [18:0] rnd      [0:2];
    logic [16:0] lim      [0:2];
    logic signed [16:0] pos6_reg [0:2];

    assign sd = qv_t'(trig.sd);
    assign cd = qv_t'(trig.cd);
    assign sh = qv_t'(trig.sh);
    assign ch = qv_t'(trig.ch);
    assign sl = qv_t'(trig.sl);
    assign cl = qv_t'(trig.cl);
    assign so = qv_t'(trig.so);
    assign co = qv_t'(trig.co);

    // first products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdcl1 <= mulq(cd, cl);
            cdsl1 <= mulq(cd, sl);
            slsd1 <= mulq(sl, sd);
            east1 <= -mulq(cd, sh);
            sdcl1 <= mulq(sd, cl);
            slco1 <= mulq(sl, co);
            clco1 <= mulq(cl, co);
            slso1 <= mulq(sl, so);
            clso1 <= mulq(cl, so);
            ch1   <= ch;
            so1   <= so;
            co1   <= co;
            cl1   <= cl;
            sl1   <= sl;
        end
    end

    // up and north
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up2    <= slsd1 + mulq(cdcl1, ch1);
            north2 <= sdcl1 - mulq(cdsl1, ch1);
            east2  <= east1;
            slco2  <= slco1;
            clco2  <= clco1;
            slso2  <= slso1;
            clso2  <= clso1;
            so2    <= so1;
            co2    <= co1;
            cl2    <= cl1;
            sl2    <= sl1;
        end
    end

    // rotation terms into Earth-centred axes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg[0] <= -mulq(so2, east2);
            tx_reg[1] <= -mulq(slco2, north2);
            tx_reg[2] <= mulq(clco2, up2);
            ty_reg[0] <= mulq(co2, east2);
            ty_reg[1] <= -mulq(slso2, north2);
            ty_reg[2] <= mulq(clso2, up2);
            tz_reg[0] <= mulq(cl2, north2);
            tz_reg[1] <= mulq(sl2, up2);
            vis3_reg  <= up2 > ALT_FLOOR;
        end
    end

    // sums split into magnitude and sign
    always_comb
    begin
        ec[0] = tx_reg[0] + tx_reg[1] + tx_reg[2];
        ec[1] = ty_reg[0] + ty_reg[1] + ty_reg[2];
        ec[2] = tz_reg[0] + tz_reg[1];
    end

    // scale, round and limit
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = 19'((mp5_reg[i] + (49'd1 << 29)) >> 30);
            lim[i] = (rnd[i] > POS_MAX) ? 17'(POS_MAX) : rnd[i][16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis4_reg <= vis3_reg;
            vis5_reg <= vis4_reg;
            vis6_reg <= vis5_reg;
            for (int i = 0; i < 3; i++)
            begin
                mag4_reg[i] <= ec[i][33] ? 33'(-ec[i]) : 33'(ec[i]);
                neg4_reg[i] <= ec[i][33];
                mp5_reg[i]  <= {16'b0, mag4_reg[i]} * {33'b0, SKY_SCALE};
                neg5_reg[i] <= neg4_reg[i];
                pos6_reg[i] <= neg5_reg[i] ? -$signed(lim[i]) : $signed(lim[i]);
            end
        end
    end

    assign visible = vis6_reg;
    assign pos     = pos6_reg;

endmodule

/* rtl/core/scs_tone.sv */
module scs_tone
    import scs_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [7:0]  magnitude_code,
    input  logic [7:0]  colour_index_code,
    output logic [14:0] brightness,
    output logic [15:0] tint [0:2]
);

    logic signed [11:0] w;
    logic signed [11:0] wc;
    logic [2:0]  seg;
    logic [8:0]  num;
    logic [8:0]  den;
    logic [6:0]  pa, pb;
    logic [14:0] n;
    logic [29:0] nt [0:2];
    logic signed [11:0] nb;

    logic [29:0] nt1_reg [0:2];
    logic        hi1_reg;
    logic [27:0] nb1_reg;
    logic        low1_reg;
    logic [47:0] pt2_reg [0:2];
    logic [29:0] nt2_reg [0:2];
    logic        hi2_reg;
    logic [47:0] pb2_reg;
    logic [27:0] nb2_reg;
    logic        low2_reg;
    logic [15:0] tint3_reg [0:2];
    logic [14:0] br3_reg;

    logic [15:0] tq0;
    logic [30:0] trem;
    logic [14:0] tdiv;
    logic [16:0] tq [0:2];
    logic [15:0] bq0;
    logic [28:0] brem;
    logic [16:0] bq;

    // segment select and numerators
    always_comb
    begin
        w   = $signed({4'b0, colour_index_code}) * 12'sd6 - 12'sd255;
        wc  = (w < -12'sd204) ? -12'sd204 : ((w > 12'sd918) ? 12'sd918 : w);
        seg = 3'd0;
        num = 9'd0;
        den = 9'd204;
        if (wc < 12'sd0)
        begin
            seg = 3'd0;
            num = 9'(wc + 12'sd204);
            den = 9'd204;
        end
        else if (wc < 12'sd306)
        begin
            seg = 3'd1;
            num = 9'(wc);
            den = 9'd306;
        end
        else if (wc < 12'sd612)
        begin
            seg = 3'd2;
            num = 9'(wc - 12'sd306);
            den = 9'd306;
        end
        else
        begin
            seg = 3'd3;
            num = 9'(wc - 12'sd612);
            den = 9'd306;
        end
        for (int c = 0; c < 3; c++)
        begin
            pa    = TINT_PT[seg][c];
            pb    = TINT_PT[seg + 3'd1][c];
            n     = {8'b0, pa} * {6'b0, den - num} + {8'b0, pb} * {6'b0, num};
            nt[c] = {n, 15'b0} + {21'b0, den} * 30'd50;
        end
        nb = 12'sd1105 - $signed({4'b0, magnitude_code}) * 12'sd7;
    end

    // quotient correction
    always_comb
    begin
        tdiv = hi2_reg ? TINT_DIV_HI : TINT_DIV_LO;
        for (int c = 0; c < 3; c++)
        begin
            tq0   = pt2_reg[c][47:32];
            trem  = {1'b0, nt2_reg[c]} - {15'b0, tq0} * {16'b0, tdiv};
            tq[c] = {1'b0, tq0} + 17'(trem >= {16'b0, tdiv});
        end
        bq0  = pb2_reg[47:32];
        brem = {1'b0, nb2_reg} - {13'b0, bq0} * {16'b0, BR_DIV};
        bq   = {1'b0, bq0} + 17'(brem >= {16'b0, BR_DIV});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nt1_reg  <= nt;
            hi1_reg  <= (den == 9'd306);
            nb1_reg  <= {nb[10:0], 17'b0} + 28'd2125;
            low1_reg <= (nb <= 12'sd0);
            for (int c = 0; c < 3; c++)
            begin
                pt2_reg[c] <= {18'b0, nt1_reg[c]}
                    * {30'b0, (hi1_reg ? TINT_RECIP_HI : TINT_RECIP_LO)};
                nt2_reg[c]   <= nt1_reg[c];
                tint3_reg[c] <= tq[c][15:0];
            end
            hi2_reg  <= hi1_reg;
            pb2_reg  <= {20'b0, nb1_reg} * {28'b0, BR_RECIP};
            nb2_reg  <= nb1_reg;
            low2_reg <= low1_reg;
            if (low2_reg || bq < {2'b0, BR_LOW})
            begin
                br3_reg <= BR_LOW;
            end
            else if (bq > {2'b0, BR_HIGH})
            begin
                br3_reg <= BR_HIGH;
            end
            else
            begin
                br3_reg <= bq[14:0];
            end
        end
    end

    assign brightness = br3_reg;
    assign tint       = tint3_reg;

endmodule

/* rtl/core/star_catalogue_to_sky_position.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata star record, tlast last_star
// m_*       out  m_tvalid/m_tready  tdata sky position, tuser visible, tlast final_record
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One star per cycle unless stalled; front stage, sine units, frame, then the output register.
// The depth is set by the sine units: six series terms of three stages each.
// rst_n clears the valid bits and the three configuration registers.
// One stall signal freezes every stage while the output register holds an untaken transfer.
module star_catalogue_to_sky_position
    import scs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // ra_code, dec_code, magnitude_code, colour_index_code
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // pos_x, pos_y, pos_z, brightness, tint_red, tint_green,
                                    // tint_blue, zero fill
    output logic         m_tuser,   // visible
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    typedef struct packed {
        logic       last;
        logic [7:0] mag;
        logic [7:0] col;
    } side_t;

    logic [15:0] sidereal_reg, latitude_reg, longitude_reg;
    logic        en;

    logic [16:0] dmag;
    logic [31:0] decmag;
    logic [31:0] dec_reg;
    logic [15:0] ha_reg, lat_reg, lon_reg;

    logic  vld_reg  [0:PIPE_LAT];
    side_t side_reg [0:PIPE_LAT];

    logic [31:0] ang [0:7];
    logic signed [31:0] tv [0:7];
    trig_t trig;

    logic               vis;
    logic signed [16:0] pos [0:2];
    logic [14:0]        bright;
    logic [15:0]        tint [0:2];

    logic         out_vld_reg;
    logic [119:0] out_data_reg;
    logic         out_vis_reg;
    logic         out_last_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidereal_reg  <= '0;
            latitude_reg  <= '0;
            longitude_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SIDEREAL:  sidereal_reg  <= cfg_wdata;
                REG_LATITUDE:  latitude_reg  <= cfg_wdata;
                REG_LONGITUDE: longitude_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // declination to binary angle: |code| * 2^30 / 32767 rounded
    always_comb
    begin
        dmag   = s_tdata[31] ? (17'h10000 - {1'b0, s_tdata[31:16]}) : {1'b0, s_tdata[31:16]};
        decmag = {dmag, 15'b0} + 32'(dmag) + 32'(dmag >= 17'd16384);
    end

    // front stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg     <= s_tdata[31] ? -decmag : decmag;
            ha_reg      <= sidereal_reg - s_tdata[15:0];
            lat_reg     <= latitude_reg;
            lon_reg     <= longitude_reg;
            side_reg[0] <= '{last: s_tlast, mag: s_tdata[39:32], col: s_tdata[47:40]};
            for (int k = 1; k <= PIPE_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= PIPE_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= PIPE_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // sine units, cosine as sine a quarter turn on
    assign ang[0] = dec_reg;
    assign ang[1] = dec_reg + QUARTER_TURN;
    assign ang[2] = {ha_reg, 16'b0};
    assign ang[3] = {ha_reg, 16'b0} + QUARTER_TURN;
    assign ang[4] = {lat_reg, 16'b0};
    assign ang[5] = {lat_reg, 16'b0} + QUARTER_TURN;
    assign ang[6] = {lon_reg, 16'b0};
    assign ang[7] = {lon_reg, 16'b0} + QUARTER_TURN;

    for (genvar i = 0; i < 8; i++)
    begin : g_sin
        scs_sin u_sin (
            .clk   (clk),
            .en    (en),
            .angle (ang[i]),
            .value (tv[i])
        );
    end

    assign trig = '{sd: tv[0], cd: tv[1], sh: tv[2], ch: tv[3],
                    sl: tv[4], cl: tv[5], so: tv[6], co: tv[7]};

    scs_frame u_frame (
        .clk     (clk),
        .en      (en),
        .trig    (trig),
        .visible (vis),
        .pos     (pos)
    );

    scs_tone u_tone (
        .clk               (clk),
        .en                (en),
        .magnitude_code    (side_reg[PIPE_LAT-TONE_LAT].mag),
        .colour_index_code (side_reg[PIPE_LAT-TONE_LAT].col),
        .brightness        (bright),
        .tint              (tint)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[PIPE_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vis_reg  <= vis;
            out_last_reg <= side_reg[PIPE_LAT].last;
            out_data_reg <= vis ? {6'b0, tint[2], tint[1], tint[0], bright,
                                   pos[2], pos[1], pos[0]} : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_vis_reg;
    assign m_tlast  = out_last_reg;

endmodule
